@@ design/altok_pkg.sv @@
// shared types, constants and helpers for the assembly line tokenizer
package altok_pkg;

    localparam int LINE_MAX = 256;
    localparam int POS_W    = $clog2(LINE_MAX + 1);
    localparam int CQ_DEPTH = 4;
    localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_USCORE = 8'h5f;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ESC    = 8'h1b;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [8:0] LEN_SAT   = 9'h1ff;

    localparam logic [2:0] KIND_WORD  = 3'd0;
    localparam logic [2:0] KIND_STR   = 3'd1;
    localparam logic [2:0] KIND_CHAR  = 3'd2;
    localparam logic [2:0] KIND_PUNCT = 3'd3;
    localparam logic [2:0] KIND_END   = 3'd4;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_UNTERM  = 2'd1;
    localparam logic [1:0] ERR_BADCHAR = 2'd2;
    localparam logic [1:0] ERR_LONG    = 2'd3;

    // one classified input beat
    typedef struct packed {
        logic [7:0] ch;
        logic [7:0] esc_val;
        logic       eol;
        logic       nul;
        logic       space;
        logic       word_start;
        logic       word_cont;
        logic       dquote;
        logic       squote;
        logic       bslash;
        logic       comment;
    } cls_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] start;
        logic [8:0] len;
        logic [7:0] val;
        logic [1:0] err;
        logic       last;
    } res_t;

    function automatic logic [8:0] sat_len(input logic [POS_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        if (w > 32'(LEN_SAT))
        begin
            return LEN_SAT;
        end
        return w[8:0];
    endfunction

endpackage

@@ design/altok_front.sv @@
// front end: classifies each character and queues it for the lexer
module altok_front
    import altok_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] ch,
    input  logic       end_of_line,
    output logic       cq_valid,
    output cls_t       cq_head,
    input  logic       cq_pop
);

    cls_t                cq_mem_reg [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CQ_CNT_W-1:0] cnt_reg, cnt_next;
    cls_t                cls;
    logic                wr_en;
    logic                rd_en;
    logic                alnum;

    function automatic logic [7:0] map_escape(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            8'h61:   r = 8'h07;
            8'h62:   r = 8'h08;
            8'h65:   r = CH_ESC;
            8'h66:   r = 8'h0c;
            8'h6e:   r = 8'h0a;
            8'h72:   r = 8'h0d;
            8'h74:   r = 8'h09;
            default: r = c;
        endcase
        return r;
    endfunction

    always_comb
    begin
        alnum = (ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h41 && ch <= 8'h5a)
              || (ch >= 8'h61 && ch <= 8'h7a);
        cls.ch         = ch;
        cls.esc_val    = map_escape(ch);
        cls.eol        = end_of_line;
        cls.nul        = (ch == CH_NUL);
        cls.space      = (ch == CH_SPACE) || (ch >= 8'h09 && ch <= 8'h0d);
        cls.word_cont  = alnum || (ch == CH_USCORE);
        cls.word_start = alnum || (ch == CH_USCORE) || (ch == CH_DOT)
                       || (ch == CH_DOLLAR) || (ch == CH_PCT);
        cls.dquote     = (ch == CH_DQUOTE);
        cls.squote     = (ch == CH_SQUOTE);
        cls.bslash     = (ch == CH_BSLASH);
        cls.comment    = (ch == CH_SEMI) || (ch == CH_BANG);
    end

    assign full     = (cnt_reg == CQ_CNT_W'(CQ_DEPTH));
    assign cq_valid = (cnt_reg != '0);
    assign cq_head  = cq_mem_reg[rd_ptr_reg];
    assign wr_en    = push && !full;
    assign rd_en    = cq_pop && cq_valid;

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + CQ_CNT_W'(wr_en) - CQ_CNT_W'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cq_mem_reg[wr_ptr_reg] <= cls;
        end
    end

    a_cq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CQ_CNT_W'(CQ_DEPTH))
        else $error("classified queue count out of range");

    a_cq_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0 || cnt_reg == CQ_CNT_W'(CQ_DEPTH)) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("classified queue pointers disagree with count");

    a_cq_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (push && full && !cq_pop) |=> full)
        else $error("classified queue took a beat while full");

endmodule

@@ design/altok_back.sv @@
// back end: lexer state machine and result queue
module altok_back
    import altok_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cq_valid,
    input  cls_t cq_head,
    output logic cq_pop,
    output logic res_valid,
    output res_t res_head,
    input  logic res_pop
);

    typedef enum logic [2:0] {
        M_IDLE,
        M_WORD,
        M_STR,
        M_STR_ESC,
        M_CH_FIRST,
        M_CH_ESC,
        M_CH_CLOSE,
        M_DONE
    } mode_t;

    mode_t               mode_reg, mode_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [POS_W-1:0]    start_reg, start_next;
    logic [7:0]          dchar_reg, dchar_next;
    logic                long_reg, long_next;

    res_t                oq_mem_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [OQ_CNT_W-1:0] cnt_reg;

    logic                take;
    logic                out_pop;
    logic [1:0]          n_res;
    res_t                res0, res1, pend, end_res, punct;
    logic                pend_valid;
    logic                begin_tok;
    logic [POS_W-1:0]    len_here;
    logic [POS_W-1:0]    len_incl;

    assign take      = cq_valid && (cnt_reg <= OQ_CNT_W'(OQ_DEPTH - 2));
    assign cq_pop    = take;
    assign res_valid = (cnt_reg != '0);
    assign res_head  = oq_mem_reg[rd_ptr_reg];
    assign out_pop   = res_pop && res_valid;
    assign len_here  = pos_reg - start_reg;
    assign len_incl  = pos_reg + 1'b1 - start_reg;

    // token cut short by line end or nul
    always_comb
    begin
        pend       = '0;
        pend.start = 8'(start_reg);
        pend.len   = sat_len(len_here);
        pend_valid = 1'b1;
        unique case (mode_reg)
            M_WORD:
            begin
                pend.kind = KIND_WORD;
            end
            M_STR, M_STR_ESC:
            begin
                pend.kind = KIND_STR;
                pend.err  = ERR_UNTERM;
            end
            M_CH_FIRST, M_CH_ESC:
            begin
                pend.kind = KIND_CHAR;
                pend.err  = ERR_BADCHAR;
            end
            M_CH_CLOSE:
            begin
                pend.kind = KIND_CHAR;
                pend.err  = ERR_BADCHAR;
                pend.val  = dchar_reg;
            end
            default:
            begin
                pend_valid = 1'b0;
            end
        endcase

        end_res      = '0;
        end_res.kind = KIND_END;
        end_res.err  = long_reg ? ERR_LONG : ERR_NONE;
        end_res.last = 1'b1;

        punct       = '0;
        punct.kind  = KIND_PUNCT;
        punct.start = 8'(pos_reg);
        punct.len   = 9'd1;
    end

    always_comb
    begin
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        start_next = start_reg;
        dchar_next = dchar_reg;
        long_next  = long_reg;
        res0       = '0;
        res1       = '0;
        n_res      = 2'd0;
        begin_tok  = 1'b0;
        if (take)
        begin
            if (cq_head.eol)
            begin
                if (pend_valid)
                begin
                    res0  = pend;
                    res1  = end_res;
                    n_res = 2'd2;
                end
                else
                begin
                    res0  = end_res;
                    n_res = 2'd1;
                end
                mode_next  = M_IDLE;
                pos_next   = '0;
                start_next = '0;
                dchar_next = '0;
                long_next  = 1'b0;
            end
            else if (pos_reg >= POS_W'(LINE_MAX))
            begin
                long_next = 1'b1;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
                if (mode_reg == M_DONE)
                begin
                    mode_next = M_DONE;
                end
                else if (cq_head.nul)
                begin
                    if (pend_valid)
                    begin
                        res0  = pend;
                        n_res = 2'd1;
                    end
                    mode_next = M_DONE;
                end
                else
                begin
                    unique case (mode_reg)
                        M_IDLE:
                        begin
                            begin_tok = 1'b1;
                        end
                        M_WORD:
                        begin
                            if (!cq_head.word_cont)
                            begin
                                res0       = '0;
                                res0.kind  = KIND_WORD;
                                res0.start = 8'(start_reg);
                                res0.len   = sat_len(len_here);
                                n_res      = 2'd1;
                                mode_next  = M_IDLE;
                                begin_tok  = 1'b1;
                            end
                        end
                        M_STR:
                        begin
                            if (cq_head.dquote)
                            begin
                                res0.kind  = KIND_STR;
                                res0.start = 8'(start_reg);
                                res0.len   = sat_len(len_incl);
                                n_res      = 2'd1;
                                mode_next  = M_IDLE;
                            end
                            else if (cq_head.bslash)
                            begin
                                mode_next = M_STR_ESC;
                            end
                        end
                        M_STR_ESC:
                        begin
                            mode_next = M_STR;
                        end
                        M_CH_FIRST:
                        begin
                            if (cq_head.bslash)
                            begin
                                mode_next = M_CH_ESC;
                            end
                            else
                            begin
                                dchar_next = cq_head.ch;
                                mode_next  = M_CH_CLOSE;
                            end
                        end
                        M_CH_ESC:
                        begin
                            dchar_next = cq_head.esc_val;
                            mode_next  = M_CH_CLOSE;
                        end
                        M_CH_CLOSE:
                        begin
                            res0.kind  = KIND_CHAR;
                            res0.start = 8'(start_reg);
                            res0.len   = sat_len(len_incl);
                            res0.val   = dchar_reg;
                            res0.err   = cq_head.squote ? ERR_NONE : ERR_BADCHAR;
                            n_res      = 2'd1;
                            mode_next  = M_IDLE;
                        end
                        default:
                        begin
                            mode_next = mode_reg;
                        end
                    endcase

                    // the character that ends a word is also a token start
                    if (begin_tok && !cq_head.space)
                    begin
                        if (cq_head.comment)
                        begin
                            mode_next = M_DONE;
                        end
                        else
                        begin
                            start_next = pos_reg;
                            if (cq_head.word_start)
                            begin
                                mode_next = M_WORD;
                            end
                            else if (cq_head.dquote)
                            begin
                                mode_next = M_STR;
                            end
                            else if (cq_head.squote)
                            begin
                                dchar_next = '0;
                                mode_next  = M_CH_FIRST;
                            end
                            else if (n_res == 2'd0)
                            begin
                                res0  = punct;
                                n_res = 2'd1;
                            end
                            else
                            begin
                                res1  = punct;
                                n_res = 2'd2;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            pos_reg   <= '0;
            start_reg <= '0;
            dchar_reg <= '0;
            long_reg  <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            dchar_reg <= dchar_next;
            long_reg  <= long_next;
        end
    end

    // result queue takes up to two beats per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + OQ_PTR_W'(n_res);
            rd_ptr_reg <= out_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
            cnt_reg    <= cnt_reg + OQ_CNT_W'(n_res) - OQ_CNT_W'(out_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (n_res != 2'd0)
        begin
            oq_mem_reg[wr_ptr_reg] <= res0;
        end
        if (n_res == 2'd2)
        begin
            oq_mem_reg[wr_ptr_reg + 1'b1] <= res1;
        end
    end

    a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= OQ_CNT_W'(OQ_DEPTH))
        else $error("result queue overflow");

    a_eol_last: assert property (@(posedge clk) disable iff (!rst_n)
        (take && cq_head.eol) |-> ((n_res == 2'd1 && res0.last)
                                   || (n_res == 2'd2 && res1.last && !res0.last)))
        else $error("end marker not flagged last");

    a_eol_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (take && cq_head.eol) |=> (mode_reg == M_IDLE && pos_reg == '0 && !long_reg))
        else $error("line state not cleared after end marker");

    a_pair_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (n_res == 2'd2) |-> (res1.kind == KIND_END || res1.kind == KIND_PUNCT))
        else $error("unexpected second result");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(LINE_MAX))
        else $error("line position beyond limit");

endmodule

@@ design/assembly_line_tokenizer_core.sv @@
// top level of the assembly line tokenizer
// throughput: one character per cycle unless full; while the result queue has room for two,
// the lexer retires one queued beat per cycle and writes up to two results at once, so output
// rate is set by pop, one result a cycle
// reset: asynchronous active-low rst_n empties both queues and returns the lexer
// to idle at line position zero
module assembly_line_tokenizer_core
    import altok_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] ch,
    input  logic       end_of_line,
    output logic       empty,
    input  logic       pop,
    output logic [2:0] token_kind,
    output logic [7:0] start_pos,
    output logic [8:0] token_length,
    output logic [7:0] char_value,
    output logic [1:0] error_code,
    output logic       last
);

    logic cq_valid;
    cls_t cq_head;
    logic cq_pop;
    logic res_valid;
    res_t res_head;

    altok_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .ch          (ch),
        .end_of_line (end_of_line),
        .cq_valid    (cq_valid),
        .cq_head     (cq_head),
        .cq_pop      (cq_pop)
    );

    altok_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cq_valid  (cq_valid),
        .cq_head   (cq_head),
        .cq_pop    (cq_pop),
        .res_valid (res_valid),
        .res_head  (res_head),
        .res_pop   (pop)
    );

    assign empty        = !res_valid;
    assign token_kind   = res_head.kind;
    assign start_pos    = res_head.start;
    assign token_length = res_head.len;
    assign char_value   = res_head.val;
    assign error_code   = res_head.err;
    assign last         = res_head.last;

endmodule
